### rtl/core/http_chunked_body_decoder_macros.svh
// Assertion macros used by the checker of the chunked body decoder.
// Both expect a signal named clk, and HCBD_ASSERT also arst_n, in the scope where they are used.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Checked only outside reset.
`define HCBD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define HCBD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/hcbd_pkg.sv
package hcbd_pkg;

	localparam int COUNT_BITS = 32;
	localparam int HEX_BITS   = 4;

	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_HT    = 8'h09;
	localparam logic [7:0] CHAR_VT    = 8'h0B;
	localparam logic [7:0] CHAR_FF    = 8'h0C;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UF    = 8'h46;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF_HEX = 8'h66;
	localparam logic [7:0] CHAR_UX    = 8'h58;
	localparam logic [7:0] CHAR_LX    = 8'h78;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_HDR_OVF,
		PH_DATA,
		PH_FOOTER,
		PH_DONE,
		PH_HERR,
		PH_FERR
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD,
		KIND_END,
		KIND_HERR,
		KIND_FERR
	} kind_t;

	typedef enum logic [1:0] {
		PFX_BLANK,
		PFX_ZERO,
		PFX_X,
		PFX_DIGITS
	} prefix_t;

	typedef struct packed {
		logic       action;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} result_t;

	typedef struct packed {
		logic                ok;
		logic [HEX_BITS-1:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b0;
		h.val = '0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			h.ok  = 1'b1;
			h.val = c[3:0];
		end else if ((c >= CHAR_LA && c <= CHAR_LF_HEX) || (c >= CHAR_UA && c <= CHAR_UF)) begin
			h.ok  = 1'b1;
			h.val = c[3:0] + 4'd9;
		end
		return h;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CHAR_SPACE || c == CHAR_HT || c == CHAR_VT || c == CHAR_FF
			|| c == CHAR_CR;
	endfunction

endpackage

### rtl/core/hcbd_in_if.sv
interface hcbd_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] in_byte;

	modport source (output valid, output action, output in_byte, input ready);
	modport sink   (input valid, input action, input in_byte, output ready);
endinterface

### rtl/core/hcbd_out_if.sv
interface hcbd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       chunk_end;

	modport source (output valid, output kind, output out_byte, output chunk_end, input ready);
	modport sink   (input valid, input kind, input out_byte, input chunk_end, output ready);
endinterface

### rtl/core/hcbd_step.sv
module hcbd_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  hcbd_pkg::item_t   item,
	output hcbd_pkg::result_t res
);

	hcbd_pkg::phase_t                    phase_q, phase_d;
	hcbd_pkg::prefix_t                   prefix_q, prefix_d;
	logic [hcbd_pkg::COUNT_BITS-1:0]     remaining_q, remaining_d;
	logic                                digit_seen_q, digit_seen_d;
	logic                                digits_ended_q, digits_ended_d;
	logic                                pending_cr_q, pending_cr_d;
	logic                                line_nonempty_q, line_nonempty_d;
	hcbd_pkg::hex_t                      hx;
	logic [hcbd_pkg::COUNT_BITS-1:0]     rem_dec;
	logic [7:0]                          c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= hcbd_pkg::PH_HEADER;
			prefix_q        <= hcbd_pkg::PFX_BLANK;
			remaining_q     <= '0;
			digit_seen_q    <= 1'b0;
			digits_ended_q  <= 1'b0;
			pending_cr_q    <= 1'b0;
			line_nonempty_q <= 1'b0;
		end else if (adv) begin
			phase_q         <= phase_d;
			prefix_q        <= prefix_d;
			remaining_q     <= remaining_d;
			digit_seen_q    <= digit_seen_d;
			digits_ended_q  <= digits_ended_d;
			pending_cr_q    <= pending_cr_d;
			line_nonempty_q <= line_nonempty_d;
		end
	end

	assign c       = item.data;
	assign hx      = hcbd_pkg::hex_decode(item.data);
	assign rem_dec = remaining_q - 1'b1;

	always_comb begin
		phase_d         = phase_q;
		prefix_d        = prefix_q;
		remaining_d     = remaining_q;
		digit_seen_d    = digit_seen_q;
		digits_ended_d  = digits_ended_q;
		pending_cr_d    = pending_cr_q;
		line_nonempty_d = line_nonempty_q;
		res.valid       = 1'b0;
		res.kind        = hcbd_pkg::KIND_PAYLOAD;
		res.data        = '0;
		res.last        = 1'b0;

		if (item.action) begin
			phase_d         = hcbd_pkg::PH_HEADER;
			prefix_d        = hcbd_pkg::PFX_BLANK;
			remaining_d     = '0;
			digit_seen_d    = 1'b0;
			digits_ended_d  = 1'b0;
			pending_cr_d    = 1'b0;
			line_nonempty_d = 1'b0;
		end else begin
			unique case (phase_q)
				hcbd_pkg::PH_HEADER, hcbd_pkg::PH_HDR_OVF: begin
					if (c == hcbd_pkg::CHAR_LF) begin
						prefix_d        = hcbd_pkg::PFX_BLANK;
						digit_seen_d    = 1'b0;
						digits_ended_d  = 1'b0;
						pending_cr_d    = 1'b0;
						line_nonempty_d = 1'b0;
						res.valid       = 1'b1;
						if (phase_q == hcbd_pkg::PH_HDR_OVF || !digit_seen_q) begin
							phase_d  = hcbd_pkg::PH_HERR;
							res.kind = hcbd_pkg::KIND_HERR;
						end else if (remaining_q == '0) begin
							phase_d  = hcbd_pkg::PH_DONE;
							res.kind = hcbd_pkg::KIND_END;
						end else begin
							phase_d   = hcbd_pkg::PH_DATA;
							res.valid = 1'b0;
						end
					end else if (phase_q == hcbd_pkg::PH_HEADER && !digits_ended_q) begin
						if (prefix_q == hcbd_pkg::PFX_BLANK) begin
							if (hcbd_pkg::is_blank(c)) begin
								prefix_d = prefix_q;
							end else if (c == hcbd_pkg::CHAR_ZERO) begin
								digit_seen_d = 1'b1;
								remaining_d  = '0;
								prefix_d     = hcbd_pkg::PFX_ZERO;
							end else if (hx.ok) begin
								digit_seen_d = 1'b1;
								remaining_d  = {{(hcbd_pkg::COUNT_BITS-hcbd_pkg::HEX_BITS){1'b0}},
									hx.val};
								prefix_d     = hcbd_pkg::PFX_DIGITS;
							end else begin
								digits_ended_d = 1'b1;
							end
						end else if (prefix_q == hcbd_pkg::PFX_ZERO
							&& (c == hcbd_pkg::CHAR_LX || c == hcbd_pkg::CHAR_UX)) begin
							prefix_d = hcbd_pkg::PFX_X;
						end else if (hx.ok) begin
							prefix_d = hcbd_pkg::PFX_DIGITS;
							// A digit that would push a set bit out of the counter overflows.
							if (remaining_q[hcbd_pkg::COUNT_BITS-1 -: hcbd_pkg::HEX_BITS] != '0) begin
								phase_d = hcbd_pkg::PH_HDR_OVF;
							end else begin
								remaining_d = {remaining_q[hcbd_pkg::COUNT_BITS-hcbd_pkg::HEX_BITS-1:0],
									hx.val};
							end
						end else begin
							digits_ended_d = 1'b1;
						end
					end
				end
				hcbd_pkg::PH_DATA: begin
					remaining_d = rem_dec;
					res.valid   = 1'b1;
					res.data    = c;
					if (rem_dec == '0) begin
						phase_d         = hcbd_pkg::PH_FOOTER;
						prefix_d        = hcbd_pkg::PFX_BLANK;
						digit_seen_d    = 1'b0;
						digits_ended_d  = 1'b0;
						pending_cr_d    = 1'b0;
						line_nonempty_d = 1'b0;
						res.last        = 1'b1;
					end
				end
				hcbd_pkg::PH_FOOTER: begin
					if (c == hcbd_pkg::CHAR_LF) begin
						prefix_d        = hcbd_pkg::PFX_BLANK;
						digit_seen_d    = 1'b0;
						digits_ended_d  = 1'b0;
						pending_cr_d    = 1'b0;
						line_nonempty_d = 1'b0;
						if (line_nonempty_q) begin
							phase_d   = hcbd_pkg::PH_FERR;
							res.valid = 1'b1;
							res.kind  = hcbd_pkg::KIND_FERR;
						end else begin
							phase_d     = hcbd_pkg::PH_HEADER;
							remaining_d = '0;
						end
					end else begin
						// A CR counts only when the LF follows it directly.
						pending_cr_d    = (c == hcbd_pkg::CHAR_CR);
						line_nonempty_d = line_nonempty_q || pending_cr_q
							|| (c != hcbd_pkg::CHAR_CR);
					end
				end
				hcbd_pkg::PH_HERR: begin
					res.valid = 1'b1;
					res.kind  = hcbd_pkg::KIND_HERR;
				end
				hcbd_pkg::PH_FERR: begin
					res.valid = 1'b1;
					res.kind  = hcbd_pkg::KIND_FERR;
				end
				default: begin
					res.valid = 1'b0;
				end
			endcase
		end
	end

endmodule

### rtl/core/hcbd_out_stage.sv
module hcbd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  hcbd_pkg::result_t res_d,
	output logic              free,
	hcbd_out_if.source        res
);

	logic                valid_q;
	hcbd_pkg::kind_t     kind_q;
	logic [7:0]          data_q;
	logic                last_q;

	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load && res_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load && res_d.valid) begin
			kind_q <= res_d.kind;
			data_q <= res_d.data;
			last_q <= res_d.last;
		end
	end

	assign res.valid     = valid_q;
	assign res.kind      = kind_q;
	assign res.out_byte  = data_q;
	assign res.chunk_end = last_q;

endmodule

### rtl/core/http_chunked_body_decoder.sv
// Channel  Dir  Fields                      Handshake
// req      in   action, in_byte             valid/ready
// res      out  kind, out_byte, chunk_end   valid/ready
//
// One request per cycle is taken while the result side does not stall; the parser state updates once per byte.
// A result passes through the input register, then the result register.
// Reset is asynchronous and active low and returns the parser to a header line start.
// A stalled result holds in the result register while the input register keeps
// one more request; ready drops only when both are full.
module http_chunked_body_decoder (
	input  logic       clk,
	input  logic       arst_n,
	hcbd_in_if.sink    req,
	hcbd_out_if.source res
);

	logic              valid_s1;
	hcbd_pkg::item_t   item_s1;
	logic              adv;
	logic              free;
	hcbd_pkg::result_t step_res;

	assign adv       = valid_s1 && free;
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.action <= req.action;
			item_s1.data   <= req.in_byte;
		end
	end

	hcbd_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.res    (step_res)
	);

	hcbd_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv),
		.res_d  (step_res),
		.free   (free),
		.res    (res)
	);

endmodule

### rtl/core/hcbd_checker.sv
`include "http_chunked_body_decoder_macros.svh"

module hcbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] kind,
	input logic [7:0] out_byte,
	input logic       chunk_end
);

	`HCBD_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !res_valid, "result valid during reset")

	// A new result must belong to a request taken by the block before it.
	`HCBD_ASSERT(a_result_latency, $rose(res_valid) |-> $past(req_valid && req_ready, 2), "result without request")

	`HCBD_ASSERT(a_nonpayload_clean, res_valid && kind != hcbd_pkg::KIND_PAYLOAD |-> out_byte == 8'd0 && !chunk_end, "status result carries data")

	`HCBD_ASSERT(a_stall_holds, res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(out_byte) && $stable(chunk_end), "stalled result changed")

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.kind      (res.kind),
	.out_byte  (res.out_byte),
	.chunk_end (res.chunk_end)
);

### sim/testbench.sv
module testbench;

	localparam int ITEM_TARGET  = 1550;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [7:0] CHAR_SEMI  = 8'h3B;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_LG    = 8'h67;
	localparam logic [7:0] CHAR_LZ    = 8'h7A;

	typedef struct packed {
		hcbd_pkg::kind_t kind;
		logic [7:0]      data;
		logic            last;
	} decoded_t;

	logic clk;
	logic arst_n;

	hcbd_in_if  req();
	hcbd_out_if res();

	http_chunked_body_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Parser image kept alongside the block.
	hcbd_pkg::phase_t                cur_phase;
	logic [hcbd_pkg::COUNT_BITS-1:0] size_left;
	bit                              got_digit;
	bit                              digits_done;
	hcbd_pkg::prefix_t               prefix;
	bit                              cr_held;
	bit                              footer_dirty;

	hcbd_pkg::item_t pending[$];
	decoded_t        decoded_q[$];
	hcbd_pkg::item_t next_item;
	decoded_t        want;

	int stim_count;
	int requests_taken;
	int restarts_taken;
	int results_checked;
	int mismatches;
	int kind_seen[4];
	int quiet_cycles;

	int src_hold;
	int src_window;
	bit src_calm;
	int sink_hold;
	int sink_window;
	bit sink_calm;

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= hcbd_pkg::CHAR_ZERO && c <= hcbd_pkg::CHAR_NINE)
			return int'(c - hcbd_pkg::CHAR_ZERO);
		if (c >= hcbd_pkg::CHAR_LA && c <= hcbd_pkg::CHAR_LF_HEX)
			return int'(c - hcbd_pkg::CHAR_LA) + 10;
		if (c >= hcbd_pkg::CHAR_UA && c <= hcbd_pkg::CHAR_UF)
			return int'(c - hcbd_pkg::CHAR_UA) + 10;
		return -1;
	endfunction

	function automatic bit is_filler(input logic [7:0] c);
		return c == hcbd_pkg::CHAR_SPACE || c == hcbd_pkg::CHAR_HT || c == hcbd_pkg::CHAR_VT
			|| c == hcbd_pkg::CHAR_FF || c == hcbd_pkg::CHAR_CR;
	endfunction

	function automatic void clear_line_flags();
		got_digit    = 1'b0;
		digits_done  = 1'b0;
		prefix       = hcbd_pkg::PFX_BLANK;
		cr_held      = 1'b0;
		footer_dirty = 1'b0;
	endfunction

	function automatic void clear_parser();
		cur_phase = hcbd_pkg::PH_HEADER;
		size_left = '0;
		clear_line_flags();
	endfunction

	function automatic void queue_result(input hcbd_pkg::kind_t k, input logic [7:0] d,
		input logic l);
		decoded_t r;
		r.kind = k;
		r.data = d;
		r.last = l;
		decoded_q.push_back(r);
	endfunction

	function automatic void parse_header_byte(input logic [7:0] c);
		bit bad;
		int nib;
		logic [hcbd_pkg::HEX_BITS-1:0] nib4;
		if (c == hcbd_pkg::CHAR_LF) begin
			bad = (cur_phase == hcbd_pkg::PH_HDR_OVF) || !got_digit;
			clear_line_flags();
			if (bad) begin
				cur_phase = hcbd_pkg::PH_HERR;
				queue_result(hcbd_pkg::KIND_HERR, '0, 1'b0);
			end else if (size_left == '0) begin
				cur_phase = hcbd_pkg::PH_DONE;
				queue_result(hcbd_pkg::KIND_END, '0, 1'b0);
			end else begin
				cur_phase = hcbd_pkg::PH_DATA;
			end
			return;
		end
		if (cur_phase == hcbd_pkg::PH_HDR_OVF || digits_done) return;
		nib  = nibble_of(c);
		nib4 = nib[hcbd_pkg::HEX_BITS-1:0];
		if (prefix == hcbd_pkg::PFX_BLANK) begin
			if (is_filler(c)) return;
			if (c == hcbd_pkg::CHAR_ZERO) begin
				got_digit = 1'b1;
				size_left = '0;
				prefix    = hcbd_pkg::PFX_ZERO;
			end else if (nib >= 0) begin
				got_digit = 1'b1;
				size_left = hcbd_pkg::COUNT_BITS'(nib4);
				prefix    = hcbd_pkg::PFX_DIGITS;
			end else begin
				digits_done = 1'b1;
			end
		end else if (prefix == hcbd_pkg::PFX_ZERO
			&& (c == hcbd_pkg::CHAR_LX || c == hcbd_pkg::CHAR_UX)) begin
			prefix = hcbd_pkg::PFX_X;
		end else if (nib >= 0) begin
			prefix = hcbd_pkg::PFX_DIGITS;
			// The count must have a free top nibble before it can take another digit.
			if (size_left[hcbd_pkg::COUNT_BITS-1 -: hcbd_pkg::HEX_BITS] != '0)
				cur_phase = hcbd_pkg::PH_HDR_OVF;
			else
				size_left = {size_left[hcbd_pkg::COUNT_BITS-hcbd_pkg::HEX_BITS-1:0], nib4};
		end else begin
			digits_done = 1'b1;
		end
	endfunction

	function automatic void parse_footer_byte(input logic [7:0] c);
		bit bad;
		if (c == hcbd_pkg::CHAR_LF) begin
			bad = footer_dirty;
			clear_line_flags();
			if (bad) begin
				cur_phase = hcbd_pkg::PH_FERR;
				queue_result(hcbd_pkg::KIND_FERR, '0, 1'b0);
			end else begin
				cur_phase = hcbd_pkg::PH_HEADER;
				size_left = '0;
			end
			return;
		end
		// Only a single CR right before the LF keeps the line empty.
		if (cr_held) footer_dirty = 1'b1;
		if (c == hcbd_pkg::CHAR_CR) begin
			cr_held = 1'b1;
		end else begin
			cr_held      = 1'b0;
			footer_dirty = 1'b1;
		end
	endfunction

	function automatic void decode_step(input logic act, input logic [7:0] c);
		if (act) begin
			clear_parser();
			return;
		end
		case (cur_phase)
			hcbd_pkg::PH_HEADER, hcbd_pkg::PH_HDR_OVF: parse_header_byte(c);
			hcbd_pkg::PH_DATA: begin
				size_left = size_left - 1'b1;
				if (size_left == '0) begin
					cur_phase = hcbd_pkg::PH_FOOTER;
					clear_line_flags();
					queue_result(hcbd_pkg::KIND_PAYLOAD, c, 1'b1);
				end else begin
					queue_result(hcbd_pkg::KIND_PAYLOAD, c, 1'b0);
				end
			end
			hcbd_pkg::PH_FOOTER: parse_footer_byte(c);
			hcbd_pkg::PH_HERR: queue_result(hcbd_pkg::KIND_HERR, '0, 1'b0);
			hcbd_pkg::PH_FERR: queue_result(hcbd_pkg::KIND_FERR, '0, 1'b0);
			default: ;
		endcase
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return hcbd_pkg::CHAR_ZERO + nib;
		return ($urandom_range(0, 1) ? hcbd_pkg::CHAR_UA : hcbd_pkg::CHAR_LA) + (nib - 4'd10);
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 4))
			0: return hcbd_pkg::CHAR_SPACE;
			1: return hcbd_pkg::CHAR_HT;
			2: return hcbd_pkg::CHAR_VT;
			3: return hcbd_pkg::CHAR_FF;
			default: return hcbd_pkg::CHAR_CR;
		endcase
	endfunction

	task automatic put_byte(input logic [7:0] c, input bit counted);
		hcbd_pkg::item_t it;
		it.action = 1'b0;
		it.data   = c;
		pending.push_back(it);
		if (counted) stim_count++;
	endtask

	task automatic put_restart();
		hcbd_pkg::item_t it;
		it.action = 1'b1;
		it.data   = 8'($urandom_range(0, 255));
		pending.push_back(it);
		stim_count++;
	endtask

	task automatic put_lead(input int zeros, output bit prefixed);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) put_byte(pick_blank(), 1'b1);
		prefixed = ($urandom_range(0, 4) == 0);
		if (prefixed) begin
			put_byte(hcbd_pkg::CHAR_ZERO, 1'b1);
			put_byte($urandom_range(0, 1) ? hcbd_pkg::CHAR_LX : hcbd_pkg::CHAR_UX, 1'b1);
		end
		repeat (zeros) put_byte(hcbd_pkg::CHAR_ZERO, 1'b1);
	endtask

	task automatic put_tail();
		logic [7:0] b;
		if ($urandom_range(0, 3) == 0) begin
			put_byte(CHAR_SEMI, 1'b1);
			repeat ($urandom_range(0, 5)) begin
				b = 8'($urandom_range(0, 255));
				if (b == hcbd_pkg::CHAR_LF) b = CHAR_SEMI;
				put_byte(b, 1'b1);
			end
		end
		if ($urandom_range(0, 1)) put_byte(hcbd_pkg::CHAR_CR, 1'b1);
		put_byte(hcbd_pkg::CHAR_LF, 1'b1);
	endtask

	task automatic put_header(input logic [hcbd_pkg::COUNT_BITS-1:0] n);
		bit prefixed;
		int zeros;
		int top;
		zeros = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
		put_lead(zeros, prefixed);
		top = 0;
		for (int i = 0; i < hcbd_pkg::COUNT_BITS / hcbd_pkg::HEX_BITS; i++)
			if (n[i*hcbd_pkg::HEX_BITS +: hcbd_pkg::HEX_BITS] != '0) top = i;
		// A bare "0x" already counts as a zero size.
		if (!(n == '0 && prefixed && zeros == 0 && $urandom_range(0, 1)))
			for (int i = top; i >= 0; i--)
				put_byte(hex_char(n[i*hcbd_pkg::HEX_BITS +: hcbd_pkg::HEX_BITS]), 1'b1);
		put_tail();
	endtask

	task automatic put_oversize_header();
		bit prefixed;
		put_lead($urandom_range(0, 2), prefixed);
		put_byte(hex_char(4'($urandom_range(1, 15))), 1'b1);
		repeat (hcbd_pkg::COUNT_BITS / hcbd_pkg::HEX_BITS + $urandom_range(0, 3))
			put_byte(hex_char(4'($urandom_range(0, 15))), 1'b1);
		put_tail();
	endtask

	task automatic put_footer(input bit spoil);
		if (spoil) begin
			case ($urandom_range(0, 3))
				0: put_byte(hcbd_pkg::CHAR_CR, 1'b1);
				1: put_byte(pick_blank(), 1'b1);
				2: begin
					put_byte(hcbd_pkg::CHAR_CR, 1'b1);
					put_byte(8'($urandom_range(0, 255)) & 8'hF7, 1'b1);
				end
				default: put_byte(hex_char(4'($urandom_range(0, 15))), 1'b1);
			endcase
		end
		if ($urandom_range(0, 1)) put_byte(hcbd_pkg::CHAR_CR, 1'b1);
		put_byte(hcbd_pkg::CHAR_LF, 1'b1);
	endtask

	task automatic put_sticky();
		repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic put_body(input bit spoil);
		int chunks;
		int sz;
		int bad_at;
		chunks = $urandom_range(1, 4);
		bad_at = spoil ? $urandom_range(0, chunks - 1) : -1;
		for (int k = 0; k < chunks; k++) begin
			sz = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 8);
			put_header(hcbd_pkg::COUNT_BITS'(sz));
			repeat (sz) put_byte(8'($urandom_range(0, 255)), 1'b1);
			put_footer(k == bad_at);
			if (k == bad_at) begin
				put_sticky();
				return;
			end
		end
		put_header('0);
		// Bytes after the end of the body produce nothing.
		repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic put_bad_header();
		case ($urandom_range(0, 5))
			0: put_tail();
			1: begin
				put_byte($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS, 1'b1);
				put_byte(hex_char(4'($urandom_range(0, 15))), 1'b1);
				put_tail();
			end
			2: begin
				put_byte(pick_blank(), 1'b1);
				put_byte(pick_blank(), 1'b1);
				put_tail();
			end
			3: begin
				put_byte(8'($urandom_range(CHAR_LG, CHAR_LZ)), 1'b1);
				put_tail();
			end
			default: put_oversize_header();
		endcase
		put_sticky();
	endtask

	// A body abandoned by a restart: either a huge chunk or a header line left open.
	task automatic put_cut_short();
		logic [hcbd_pkg::COUNT_BITS-1:0] n;
		bit prefixed;
		if ($urandom_range(0, 1)) begin
			n = hcbd_pkg::COUNT_BITS'($urandom());
			if ($urandom_range(0, 1)) n = '1;
			n[hcbd_pkg::COUNT_BITS-1] = 1'b1;
			put_header(n);
			repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			put_lead($urandom_range(0, 1), prefixed);
			repeat ($urandom_range(0, 4)) put_byte(hex_char(4'($urandom_range(0, 15))), 1'b1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid   <= 1'b0;
			req.action  <= 1'b0;
			req.in_byte <= '0;
			src_hold    <= 0;
			src_window  <= 0;
			src_calm    <= 1'b0;
		end else begin
			if (src_window == 0) begin
				src_calm   <= ($urandom_range(0, 3) == 0);
				src_window <= $urandom_range(20, 150);
			end else begin
				src_window <= src_window - 1;
			end
			if (!req.valid || req.ready) begin
				if (src_hold != 0) begin
					req.valid <= 1'b0;
					src_hold  <= src_hold - 1;
				end else if (pending.size() != 0) begin
					next_item = pending.pop_front();
					req.valid   <= 1'b1;
					req.action  <= next_item.action;
					req.in_byte <= next_item.data;
					src_hold    <= pick_gap(src_calm);
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready   <= 1'b0;
			sink_hold   <= 0;
			sink_window <= 0;
			sink_calm   <= 1'b0;
		end else begin
			if (sink_window == 0) begin
				sink_calm   <= ($urandom_range(0, 3) == 0);
				sink_window <= $urandom_range(20, 150);
			end else begin
				sink_window <= sink_window - 1;
			end
			if (sink_hold != 0) begin
				res.ready <= 1'b0;
				sink_hold <= sink_hold - 1;
			end else if (!sink_calm && $urandom_range(0, 4) == 0) begin
				res.ready <= 1'b0;
				sink_hold <= pick_gap(1'b0);
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result: kind %0d, out_byte %0h, chunk_end %0b",
						res.kind, res.out_byte, res.chunk_end);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					if (res.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, res.kind);
						mismatches++;
					end
					if (res.out_byte !== want.data) begin
						$error("out_byte: expected %0h, got %0h", want.data, res.out_byte);
						mismatches++;
					end
					if (res.chunk_end !== want.last) begin
						$error("chunk_end: expected %0b, got %0b", want.last, res.chunk_end);
						mismatches++;
					end
					results_checked++;
					kind_seen[want.kind]++;
				end
			end
			if (req.valid && req.ready) begin
				requests_taken++;
				if (req.action) restarts_taken++;
				decode_step(req.action, req.in_byte);
			end
			if ((res.valid && res.ready) || (req.valid && req.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int pick;
		bit timed_out;
		clk    = 1'b0;
		arst_n = 1'b0;
		clear_parser();

		// Size one with blank, 0x prefix and an extension, then end of body.
		put_restart();
		put_byte(hcbd_pkg::CHAR_SPACE, 1'b1);
		put_byte(hcbd_pkg::CHAR_ZERO, 1'b1);
		put_byte(hcbd_pkg::CHAR_LX, 1'b1);
		put_byte(hex_char(4'd1), 1'b1);
		put_byte(CHAR_SEMI, 1'b1);
		put_byte(hcbd_pkg::CHAR_LA + 8'd4, 1'b1);
		put_byte(hcbd_pkg::CHAR_CR, 1'b1);
		put_byte(hcbd_pkg::CHAR_LF, 1'b1);
		put_byte(8'hFF, 1'b1);
		put_byte(hcbd_pkg::CHAR_CR, 1'b1);
		put_byte(hcbd_pkg::CHAR_LF, 1'b1);
		put_byte(hcbd_pkg::CHAR_ZERO, 1'b1);
		put_byte(hcbd_pkg::CHAR_LF, 1'b1);
		put_byte(8'h00, 1'b0);
		// Signed size has no digits; the header error then repeats.
		put_restart();
		put_byte(CHAR_MINUS, 1'b1);
		put_byte(hex_char(4'd1), 1'b1);
		put_byte(hcbd_pkg::CHAR_LF, 1'b1);
		put_byte(8'h7F, 1'b1);
		// Two CRs make the footer line non-empty.
		put_restart();
		put_byte(hex_char(4'd1), 1'b1);
		put_byte(hcbd_pkg::CHAR_LF, 1'b1);
		put_byte(8'h00, 1'b1);
		put_byte(hcbd_pkg::CHAR_CR, 1'b1);
		put_byte(hcbd_pkg::CHAR_CR, 1'b1);
		put_byte(hcbd_pkg::CHAR_LF, 1'b1);
		put_byte(8'hA5, 1'b1);
		// A lone 0x prefix is a zero size.
		put_restart();
		put_byte(hcbd_pkg::CHAR_ZERO, 1'b1);
		put_byte(hcbd_pkg::CHAR_UX, 1'b1);
		put_byte(hcbd_pkg::CHAR_LF, 1'b1);

		while (stim_count < ITEM_TARGET) begin
			put_restart();
			pick = $urandom_range(0, 99);
			if (pick < 72)
				put_body(1'b0);
			else if (pick < 82)
				put_body(1'b1);
			else if (pick < 92)
				put_bad_header();
			else
				put_cut_short();
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		timed_out = 1'b0;
		while (!timed_out && !(pending.size() == 0 && !req.valid && decoded_q.size() == 0)) begin
			@(negedge clk);
			if (quiet_cycles >= QUIET_LIMIT) timed_out = 1'b1;
		end

		if (timed_out) begin
			$display("CHECKS FAILED");
		end else begin
			repeat (DRAIN_CYCLES) @(negedge clk);
			$display("Sent %0d requests (%0d restarts), checked %0d results.",
				requests_taken, restarts_taken, results_checked);
			$display("Results by kind: %0d payload, %0d end of body, %0d header error, %0d %s",
				kind_seen[hcbd_pkg::KIND_PAYLOAD], kind_seen[hcbd_pkg::KIND_END],
				kind_seen[hcbd_pkg::KIND_HERR], kind_seen[hcbd_pkg::KIND_FERR],
				"footer error.");
			if (mismatches == 0)
				$display("ALL CHECKS PASSED");
			else
				$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
